// ===== rtl/stir_pkg.sv =====
// Shared types, constants and helpers for the session table idle reaper.
`default_nettype none
package stir_pkg;

  localparam int SLOTS     = 64;
  localparam int IDX_W     = $clog2(SLOTS);
  localparam int CNT_W     = IDX_W + 1;
  localparam int OUT_IDX_W = 6;

  localparam int FD_W   = 16;
  localparam int GEN_W  = 31;
  localparam int TIME_W = 32;
  localparam int OP_W   = 2;
  localparam int STAT_W = 3;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSTALL = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd1;
  localparam logic [OP_W-1:0] OP_DESTROY = 2'd2;
  localparam logic [OP_W-1:0] OP_TOUCH   = 2'd3;

  // result status codes
  localparam logic [STAT_W-1:0] ST_FOUND     = 3'd0;
  localparam logic [STAT_W-1:0] ST_INSTALLED = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] ST_DISABLED  = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;
  localparam logic [STAT_W-1:0] ST_DESTROYED = 3'd5;

  // configuration register indexes
  localparam logic CFG_ENABLE     = 1'b0;
  localparam logic CFG_IDLE_LIMIT = 1'b1;

  localparam logic [TIME_W-1:0] IDLE_LIMIT_RST = 32'd300;

  typedef struct packed {
    logic [FD_W-1:0]   fd;
    logic [GEN_W-1:0]  gen;
    logic [TIME_W-1:0] last;
  } slot_entry_t;

  typedef struct packed {
    logic hit;   // valid, not reaped, key matches
    logic reap;  // valid, reaping enabled and idle past the limit
    logic free;  // usable for a new install
  } scan_res_t;

  function automatic logic [OUT_IDX_W-1:0] to_out_idx(input logic [IDX_W-1:0] idx);
    logic [OUT_IDX_W+IDX_W-1:0] ext;
    ext = {{OUT_IDX_W{1'b0}}, idx};
    return ext[OUT_IDX_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/stir_slot_mem.sv =====
// Slot payload memory: key and last-activity time, one write and one registered read port.
`default_nettype none
module stir_slot_mem
  import stir_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [IDX_W-1:0]  wr_addr,
  input  wire slot_entry_t       wr_data,
  input  wire logic [IDX_W-1:0]  rd_addr,
  output slot_entry_t            rd_data
);

  slot_entry_t mem_r [SLOTS];
  slot_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== rtl/stir_scan_unit.sv =====
// Shared per-slot compare unit: idle-age check and key match for one slot per cycle.
`default_nettype none
module stir_scan_unit
  import stir_pkg::*;
(
  input  wire slot_entry_t         ent,
  input  wire logic                ent_valid,
  input  wire logic                reap_en,
  input  wire logic [FD_W-1:0]     key_fd,
  input  wire logic [GEN_W-1:0]    key_gen,
  input  wire logic [TIME_W-1:0]   now,
  input  wire logic [TIME_W-1:0]   idle_limit,
  output scan_res_t                res
);

  logic [TIME_W-1:0] age;
  logic              key_eq;
  logic              reap;

  // age wraps when the clock goes backwards
  assign age    = now - ent.last;
  assign key_eq = (ent.fd == key_fd) && (ent.gen == key_gen);
  assign reap   = reap_en && ent_valid && (age > idle_limit);

  always_comb begin
    res.reap = reap;
    res.hit  = ent_valid && !reap && key_eq;
    res.free = !ent_valid || reap;
  end

endmodule
`default_nettype wire

// ===== rtl/session_table_idle_reaper_top.sv =====
// Top level: session table with idle reaping, scan sequencer and config registers.
//
// Usage:
//   Command channel: drive in_op, in_conn_fd, in_conn_generation, in_now_seconds
//   and raise start; the command transfers on a clock edge with start high and
//   busy low. busy stays high until the result is produced.
//   Result channel: out_valid pulses for one cycle with out_status and
//   out_slot_index; the receiver cannot stall, it must take the result then.
//   Config channel: cfg_valid/cfg_ready with cfg_index (0 enable, 1 idle limit)
//   and cfg_data; cfg_ready is always high. Write only while idle.
// Scan:
//   Every command except a disabled install scans all SLOTS entries through one
//   memory read port and one compare unit, then reports from S_DONE. A disabled
//   install skips the scan and goes straight to S_DONE. The next command can
//   transfer in the cycle out_valid is high.
// Reset:
//   rst_n is synchronous, active low. All slots become free, enable is cleared
//   and the idle limit returns to 300. No clearing pass is needed.
`default_nettype none
module session_table_idle_reaper_top
  import stir_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [OP_W-1:0]     in_op,
  input  wire logic [FD_W-1:0]     in_conn_fd,
  input  wire logic [GEN_W-1:0]    in_conn_generation,
  input  wire logic [TIME_W-1:0]   in_now_seconds,
  output logic                     out_valid,
  output logic [STAT_W-1:0]        out_status,
  output logic [OUT_IDX_W-1:0]     out_slot_index,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic                cfg_index,
  input  wire logic [TIME_W-1:0]   cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [CNT_W-1:0]     issue_cnt_r, issue_cnt_nxt;
  logic                 chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]     chk_idx_r, chk_idx_nxt;
  logic [OP_W-1:0]      op_r, op_nxt;
  logic [FD_W-1:0]      fd_r, fd_nxt;
  logic [GEN_W-1:0]     gen_r, gen_nxt;
  logic [TIME_W-1:0]    now_r, now_nxt;
  logic                 dis_r, dis_nxt;
  logic                 match_fnd_r, match_fnd_nxt;
  logic [IDX_W-1:0]     match_idx_r, match_idx_nxt;
  logic                 free_fnd_r, free_fnd_nxt;
  logic [IDX_W-1:0]     free_idx_r, free_idx_nxt;
  logic [SLOTS-1:0]     valid_r, valid_nxt;
  logic                 enable_r, enable_nxt;
  logic [TIME_W-1:0]    limit_r, limit_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]    out_status_r, out_status_nxt;
  logic [OUT_IDX_W-1:0] out_idx_r, out_idx_nxt;

  logic                 issuing;
  logic [IDX_W-1:0]     rd_addr;
  slot_entry_t          rd_data;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  slot_entry_t          mem_wdata;
  scan_res_t            scan_res;
  logic                 accept;
  logic                 cfg_xfer;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;

  assign issuing = (state_r == S_SCAN) && (issue_cnt_r < CNT_W'(SLOTS));
  assign rd_addr = issue_cnt_r[IDX_W-1:0];

  stir_slot_mem u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  stir_scan_unit u_scan (
    .ent        (rd_data),
    .ent_valid  (valid_r[chk_idx_r]),
    .reap_en    (op_r == OP_INSTALL),
    .key_fd     (fd_r),
    .key_gen    (gen_r),
    .now        (now_r),
    .idle_limit (limit_r),
    .res        (scan_res)
  );

  always_comb begin
    state_nxt      = state_r;
    issue_cnt_nxt  = issue_cnt_r;
    op_nxt         = op_r;
    fd_nxt         = fd_r;
    gen_nxt        = gen_r;
    now_nxt        = now_r;
    dis_nxt        = dis_r;
    match_fnd_nxt  = match_fnd_r;
    match_idx_nxt  = match_idx_r;
    free_fnd_nxt   = free_fnd_r;
    free_idx_nxt   = free_idx_r;
    valid_nxt      = valid_r;
    enable_nxt     = enable_r;
    limit_nxt      = limit_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    chk_vld_nxt    = issuing;
    chk_idx_nxt    = rd_addr;
    mem_we         = 1'b0;
    mem_waddr      = match_fnd_r ? match_idx_r : free_idx_r;
    mem_wdata.fd   = fd_r;
    mem_wdata.gen  = gen_r;
    mem_wdata.last = now_r;

    if (cfg_xfer) begin
      case (cfg_index)
        CFG_ENABLE:     enable_nxt = cfg_data[0];
        CFG_IDLE_LIMIT: limit_nxt  = cfg_data;
        default:        ;
      endcase
    end

    // compare stage, one slot behind the read address
    if (chk_vld_r) begin
      if (scan_res.reap) begin
        valid_nxt[chk_idx_r] = 1'b0;
      end
      if (scan_res.hit && !match_fnd_r) begin
        match_fnd_nxt = 1'b1;
        match_idx_nxt = chk_idx_r;
      end
      if (scan_res.free && !free_fnd_r) begin
        free_fnd_nxt = 1'b1;
        free_idx_nxt = chk_idx_r;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt        = in_op;
          fd_nxt        = in_conn_fd;
          gen_nxt       = in_conn_generation;
          now_nxt       = in_now_seconds;
          issue_cnt_nxt = '0;
          match_fnd_nxt = 1'b0;
          free_fnd_nxt  = 1'b0;
          dis_nxt       = (in_op == OP_INSTALL) && !enable_r;
          state_nxt     = ((in_op == OP_INSTALL) && !enable_r) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (issuing) begin
          issue_cnt_nxt = issue_cnt_r + CNT_W'(1);
        end else begin
          // last slot is compared this cycle, flags settle at this edge
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        state_nxt      = S_IDLE;
        out_valid_nxt  = 1'b1;
        out_idx_nxt    = '0;
        out_status_nxt = ST_NOT_FOUND;
        if (dis_r) begin
          out_status_nxt = ST_DISABLED;
        end else begin
          case (op_r)
            OP_INSTALL: begin
              if (match_fnd_r) begin
                out_status_nxt = ST_FOUND;
                out_idx_nxt    = to_out_idx(match_idx_r);
                mem_we         = 1'b1;
              end else if (free_fnd_r) begin
                out_status_nxt        = ST_INSTALLED;
                out_idx_nxt           = to_out_idx(free_idx_r);
                mem_we                = 1'b1;
                valid_nxt[free_idx_r] = 1'b1;
              end else begin
                out_status_nxt = ST_FULL;
              end
            end
            OP_LOOKUP: begin
              if (match_fnd_r) begin
                out_status_nxt = ST_FOUND;
                out_idx_nxt    = to_out_idx(match_idx_r);
              end
            end
            OP_DESTROY: begin
              if (match_fnd_r) begin
                out_status_nxt         = ST_DESTROYED;
                out_idx_nxt            = to_out_idx(match_idx_r);
                valid_nxt[match_idx_r] = 1'b0;
              end
            end
            OP_TOUCH: begin
              if (match_fnd_r) begin
                out_status_nxt = ST_FOUND;
                out_idx_nxt    = to_out_idx(match_idx_r);
                mem_we         = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issue_cnt_r <= '0;
      chk_vld_r   <= 1'b0;
      dis_r       <= 1'b0;
      match_fnd_r <= 1'b0;
      free_fnd_r  <= 1'b0;
      valid_r     <= '0;
      enable_r    <= 1'b0;
      limit_r     <= IDLE_LIMIT_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issue_cnt_r <= issue_cnt_nxt;
      chk_vld_r   <= chk_vld_nxt;
      dis_r       <= dis_nxt;
      match_fnd_r <= match_fnd_nxt;
      free_fnd_r  <= free_fnd_nxt;
      valid_r     <= valid_nxt;
      enable_r    <= enable_nxt;
      limit_r     <= limit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r    <= chk_idx_nxt;
    op_r         <= op_nxt;
    fd_r         <= fd_nxt;
    gen_r        <= gen_nxt;
    now_r        <= now_nxt;
    match_idx_r  <= match_idx_nxt;
    free_idx_r   <= free_idx_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot_index = out_idx_r;

`ifndef SYNTHESIS
  a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_DONE))
    else $error("result strobe without a finished command");

  a_no_result_next: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy && !out_valid))
    else $error("command transfer not followed by busy");

  a_zero_idx_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FULL || out_status == ST_DISABLED ||
                   out_status == ST_NOT_FOUND)) |-> (out_slot_index == '0))
    else $error("slot index not zero on a miss");

  a_write_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_DONE && !chk_vld_r))
    else $error("slot memory written during scan");
`endif

endmodule
`default_nettype wire

// ===== dv/session_table_idle_reaper_tb.sv =====
// Self-checking testbench for the session table idle reaper: command driver and scoreboard.
`timescale 1ns / 100ps

import stir_pkg::*;

class session_table_scoreboard;
  typedef struct {
    logic [STAT_W-1:0]    status;
    logic [OUT_IDX_W-1:0] slot;
  } reply_t;

  bit                slot_used [SLOTS];
  logic [FD_W-1:0]   slot_fd   [SLOTS];
  logic [GEN_W-1:0]  slot_gen  [SLOTS];
  logic [TIME_W-1:0] slot_seen [SLOTS];
  bit                enable;
  logic [TIME_W-1:0] idle_limit;
  reply_t            expected_replies[$];
  int                errors;
  int                commands;
  int                status_tally[6];

  function new();
    enable     = 1'b0;
    idle_limit = IDLE_LIMIT_RST;
    errors     = 0;
    commands   = 0;
    foreach (status_tally[i]) status_tally[i] = 0;
    for (int i = 0; i < SLOTS; i++) free_slot(i);
  endfunction

  function void free_slot(int i);
    slot_used[i] = 1'b0;
    slot_fd[i]   = '0;
    slot_gen[i]  = '0;
    slot_seen[i] = '0;
  endfunction

  function int matching_slot(logic [FD_W-1:0] fd, logic [GEN_W-1:0] gen);
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_used[i] && slot_fd[i] == fd && slot_gen[i] == gen) return i;
    end
    return -1;
  endfunction

  function void write_reg(logic idx, logic [TIME_W-1:0] data);
    if (idx == CFG_ENABLE) enable = data[0];
    else idle_limit = data;
  endfunction

  function int outstanding();
    return expected_replies.size();
  endfunction

  function void report_mismatch(string msg);
    errors++;
    if (errors <= 40) $display("MISMATCH @%0t: %s", $realtime, msg);
  endfunction

  // Update the slot table for one accepted command and queue the reply it must produce.
  function void accept_command(logic [OP_W-1:0] op, logic [FD_W-1:0] fd,
                               logic [GEN_W-1:0] gen, logic [TIME_W-1:0] now);
    int                hit;
    bit                claimed;
    logic [TIME_W-1:0] age;
    reply_t            r;
    hit      = -1;
    claimed  = 1'b0;
    r.status = ST_NOT_FOUND;
    r.slot   = '0;
    if (op == OP_INSTALL) begin
      if (!enable) begin
        r.status = ST_DISABLED;
      end else begin
        // reap first; age wraps modulo 2^32 when the clock steps back
        for (int i = 0; i < SLOTS; i++) begin
          age = now - slot_seen[i];
          if (slot_used[i] && age > idle_limit) free_slot(i);
        end
        hit = matching_slot(fd, gen);
        if (hit >= 0) begin
          slot_seen[hit] = now;
          r.status = ST_FOUND;
        end else begin
          r.status = ST_FULL;
          for (int i = 0; i < SLOTS; i++) begin
            if (!claimed && !slot_used[i]) begin
              slot_used[i] = 1'b1;
              slot_fd[i]   = fd;
              slot_gen[i]  = gen;
              slot_seen[i] = now;
              claimed      = 1'b1;
              hit          = i;
              r.status     = ST_INSTALLED;
            end
          end
        end
      end
    end else begin
      hit = matching_slot(fd, gen);
      if (hit >= 0) begin
        case (op)
          OP_DESTROY: begin
            free_slot(hit);
            r.status = ST_DESTROYED;
          end
          OP_TOUCH: begin
            slot_seen[hit] = now;
            r.status = ST_FOUND;
          end
          default: r.status = ST_FOUND;
        endcase
      end
    end
    if (hit >= 0) r.slot = hit[OUT_IDX_W-1:0];
    expected_replies.push_back(r);
    status_tally[r.status]++;
    commands++;
  endfunction

  function void check_result(logic [STAT_W-1:0] status, logic [OUT_IDX_W-1:0] slot);
    reply_t want;
    if (expected_replies.size() == 0) begin
      report_mismatch($sformatf("reply status %0d slot %0d with no command outstanding",
                                status, slot));
      return;
    end
    want = expected_replies.pop_front();
    if (status !== want.status)
      report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
    if (slot !== want.slot)
      report_mismatch($sformatf("slot_index %0d, expected %0d", slot, want.slot));
  endfunction
endclass

module testbench;
  localparam int KEYS = 96;

  logic                 clk;
  logic                 rst_n              = 1'b0;
  logic                 start              = 1'b0;
  logic                 busy;
  logic [OP_W-1:0]      in_op              = OP_LOOKUP;
  logic [FD_W-1:0]      in_conn_fd         = '0;
  logic [GEN_W-1:0]     in_conn_generation = '0;
  logic [TIME_W-1:0]    in_now_seconds     = '0;
  logic                 out_valid;
  logic [STAT_W-1:0]    out_status;
  logic [OUT_IDX_W-1:0] out_slot_index;
  logic                 cfg_valid          = 1'b0;
  logic                 cfg_ready;
  logic                 cfg_index          = CFG_ENABLE;
  logic [TIME_W-1:0]    cfg_data           = '0;

  session_table_scoreboard sb;
  logic [FD_W-1:0]   key_fd  [KEYS];
  logic [GEN_W-1:0]  key_gen [KEYS];
  logic [TIME_W-1:0] wall_clock;

  session_table_idle_reaper_top u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_op             (in_op),
    .in_conn_fd        (in_conn_fd),
    .in_conn_generation(in_conn_generation),
    .in_now_seconds    (in_now_seconds),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_slot_index    (out_slot_index),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("testbench: errors");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_status, out_slot_index);
  end

  // Present one command, optionally after idle cycles, and hold it until it transfers.
  task automatic send_command(logic [OP_W-1:0] op, logic [FD_W-1:0] fd,
                              logic [GEN_W-1:0] gen, logic [TIME_W-1:0] now, int idle_pct);
    int gap;
    gap = 0;
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) gap++;
    if (idle_pct > 0 && $urandom_range(15) == 0) gap += $urandom_range(1, 80);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start              <= 1'b1;
    in_op              <= op;
    in_conn_fd         <= fd;
    in_conn_generation <= gen;
    in_now_seconds     <= now;
    do @(posedge clk); while (busy);
    sb.accept_command(op, fd, gen, now);
  endtask

  task automatic wait_for_replies();
    start <= 1'b0;
    while (sb.outstanding() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Both registers go out back to back with valid held high across the two transfers.
  task automatic set_config(bit en, logic [TIME_W-1:0] limit);
    wait_for_replies();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_ENABLE;
    cfg_data  <= {{(TIME_W-1){1'b0}}, en};
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(CFG_ENABLE, {{(TIME_W-1){1'b0}}, en});
    cfg_index <= CFG_IDLE_LIMIT;
    cfg_data  <= limit;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(CFG_IDLE_LIMIT, limit);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(int items, int idle_pct, bit drains);
    int                r;
    int                pick;
    logic [OP_W-1:0]   op;
    logic [FD_W-1:0]   fd;
    logic [GEN_W-1:0]  gen;
    for (int k = 0; k < items; k++) begin
      r = $urandom_range(99);
      op = (r < 40) ? OP_INSTALL : (r < 60) ? OP_LOOKUP : (r < 75) ? OP_DESTROY : OP_TOUCH;
      if ($urandom_range(99) < 8) begin
        fd  = FD_W'($urandom);
        gen = GEN_W'($urandom);
      end else begin
        // a hot subset keeps sessions alive long enough to be hit again
        pick = ($urandom_range(99) < 60) ? $urandom_range(23) : $urandom_range(KEYS - 1);
        fd   = key_fd[pick];
        gen  = key_gen[pick];
      end
      r = $urandom_range(99);
      if (r < 20) wall_clock = wall_clock;
      else if (r < 80) wall_clock += $urandom_range(1, 40);
      else if (r < 90) wall_clock += $urandom_range(200, 400);
      else if (r < 95) wall_clock = $urandom;
      else wall_clock -= $urandom_range(1, 100);
      if (drains && $urandom_range(99) == 0) wait_for_replies();
      send_command(op, fd, gen, wall_clock, idle_pct);
    end
  endtask

  initial begin
    sb = new();
    wall_clock = '0;
    for (int i = 0; i < KEYS; i++) begin
      key_fd[i]  = FD_W'($urandom);
      key_gen[i] = GEN_W'($urandom);
      // near-miss keys: same descriptor or same generation as a neighbor
      if (i % 8 == 5) key_fd[i] = key_fd[i-1];
      if (i % 8 == 6) key_gen[i] = key_gen[i-1];
    end
    key_fd[0] = '0;
    key_gen[0] = '0;
    key_fd[1] = '1;
    key_gen[1] = '1;
    key_fd[2] = '0;
    key_gen[2] = '1;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset config: disabled, limit 300
    send_command(OP_INSTALL, 16'h0000, 31'h0, 32'd0, 0);
    send_command(OP_LOOKUP, 16'h0000, 31'h0, 32'd0, 0);
    set_config(1'b1, IDLE_LIMIT_RST);
    send_command(OP_INSTALL, 16'h0000, 31'h0, 32'd0, 0);
    send_command(OP_INSTALL, 16'hFFFF, 31'h7FFF_FFFF, 32'd100, 0);
    send_command(OP_INSTALL, 16'h0000, 31'h0, 32'd200, 0);
    send_command(OP_LOOKUP, 16'hFFFF, 31'h7FFF_FFFF, 32'd0, 0);
    send_command(OP_LOOKUP, 16'hFFFF, 31'h0, 32'd0, 0);
    send_command(OP_TOUCH, 16'hFFFF, 31'h7FFF_FFFF, 32'd250, 0);
    send_command(OP_DESTROY, 16'h0000, 31'h0, 32'd0, 0);
    send_command(OP_DESTROY, 16'h0000, 31'h0, 32'd0, 0);
    send_command(OP_TOUCH, 16'h0000, 31'h0, 32'd300, 0);
    // idle 350 > 300: reaped; idle exactly 300: kept
    send_command(OP_INSTALL, 16'h1234, 31'h5555, 32'd600, 0);
    send_command(OP_LOOKUP, 16'hFFFF, 31'h7FFF_FFFF, 32'd0, 0);
    send_command(OP_INSTALL, 16'h0000, 31'h7FFF_FFFF, 32'd900, 0);
    // clock stepping back wraps the age, so everything is reaped
    send_command(OP_INSTALL, 16'hFFFF, 31'h0, 32'd100, 0);
    send_command(OP_INSTALL, 16'h8000, 31'h4000_0000, 32'hFFFF_FFFF, 0);
    set_config(1'b1, 32'hFFFF_FFFF);
    send_command(OP_INSTALL, 16'h0001, 31'h1, 32'd0, 0);
    set_config(1'b1, 32'd0);
    send_command(OP_INSTALL, 16'h0002, 31'h2, 32'd0, 0);
    send_command(OP_TOUCH, 16'h0001, 31'h1, 32'd5, 0);
    send_command(OP_INSTALL, 16'h0003, 31'h3, 32'd5, 0);

    set_config(1'b1, 32'hFFFF_FFFF);
    run_phase(260, 0, 1'b0);
    set_config(1'b1, IDLE_LIMIT_RST);
    run_phase(260, 59, 1'b0);
    set_config(1'b1, 32'd0);
    run_phase(200, 0, 1'b0);
    set_config(1'b0, $urandom);
    run_phase(150, 30, 1'b0);
    set_config(1'b1, $urandom_range(20, 2000));
    run_phase(360, 30, 1'b1);

    wait_for_replies();
    repeat (80) @(posedge clk);
    $display("Ran %0d commands across enable off/on and idle limits 0, 300, max and random.",
             sb.commands);
    $display("Replies: %0d found, %0d new, %0d full, %0d off, %0d missing, %0d destroyed.",
             sb.status_tally[ST_FOUND], sb.status_tally[ST_INSTALLED],
             sb.status_tally[ST_FULL], sb.status_tally[ST_DISABLED],
             sb.status_tally[ST_NOT_FOUND], sb.status_tally[ST_DESTROYED]);
    if (sb.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/stir_pkg.sv
rtl/stir_slot_mem.sv
rtl/stir_scan_unit.sv
rtl/session_table_idle_reaper_top.sv
dv/session_table_idle_reaper_tb.sv
